FILE: rtl/core/tdfe_pkg.sv
// Shared types, codes and constants of the cassette record tone encoder.
package tdfe_pkg;

	// Configuration port
	localparam int unsigned ADDR_W = 4;
	localparam logic [1:0] REG_FREQ0 = 2'd0;
	localparam logic [1:0] REG_FREQ1 = 2'd1;
	localparam logic [1:0] REG_FREQ2 = 2'd2;
	localparam logic [1:0] REG_FREQ3 = 2'd3;
	localparam logic [15:0] FREQ0_RESET = 16'd2000;
	localparam logic [15:0] FREQ1_RESET = 16'd4000;
	localparam logic [15:0] FREQ2_RESET = 16'd6000;
	localparam logic [15:0] FREQ3_RESET = 16'd8000;

	// Input commands
	localparam logic [1:0] CMD_DATA    = 2'd0;
	localparam logic [1:0] CMD_HEADER  = 2'd1;
	localparam logic [1:0] CMD_SILENCE = 2'd2;

	// Header actions
	localparam logic [2:0] ACT_JUMP   = 3'd0;
	localparam logic [2:0] ACT_CALL   = 3'd1;
	localparam logic [2:0] ACT_NOP    = 3'd2;
	localparam logic [2:0] ACT_RETURN = 3'd3;
	localparam logic [2:0] ACT_CUSTOM = 3'd4;

	// Header bytes
	localparam logic [7:0]  OPC_JMP   = 8'h4C;
	localparam logic [7:0]  OPC_JSR   = 8'h20;
	localparam logic [7:0]  OPC_RTS   = 8'h60;
	localparam logic [7:0]  OPC_NOP   = 8'hEA;
	localparam logic [7:0]  MARK_BYTE = 8'hEA;
	localparam logic [15:0] FILL_WORD = 16'hEAEA;
	localparam int unsigned HDR_BYTES = 6;
	localparam logic [2:0]  HDR_LAST  = 3'(HDR_BYTES - 1);

	// Tone kinds and their fixed shapes
	localparam logic [2:0]  KIND_PILOT   = 3'd0;
	localparam logic [2:0]  KIND_SYNC    = 3'd1;
	localparam logic [2:0]  KIND_DATA    = 3'd2;
	localparam logic [2:0]  KIND_END     = 3'd3;
	localparam logic [2:0]  KIND_SILENCE = 3'd4;
	localparam logic [15:0] PILOT_FREQ    = 16'd5000;
	localparam logic [15:0] PILOT_CYCLES  = 16'd500;
	localparam logic [15:0] SYNC_FREQ     = 16'd10000;
	localparam logic [15:0] SYNC_CYCLES   = 16'd2;
	localparam logic [15:0] END_FREQ      = 16'd3500;
	localparam logic [15:0] END_CYCLES    = 16'd2;
	localparam logic [15:0] SYMBOL_CYCLES = 16'd1;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  data_byte;
		logic        first_flag;
		logic        last_flag;
		logic [15:0] load_address;
		logic [2:0]  action;
		logic [23:0] jump_word;
		logic [15:0] silence_length;
	} request_t;

	typedef struct packed {
		logic [2:0]  tone_kind;
		logic [1:0]  symbol;
		logic [15:0] frequency_hz;
		logic [15:0] cycle_count;
		logic        last;
	} result_t;

	// One classified item, ready for the tone sequencer.
	typedef struct packed {
		logic                        silence;
		logic                        rec_open;
		logic                        rec_close;
		logic [2:0]                  byte_last;
		logic [HDR_BYTES-1:0][7:0]   bytes;
		logic [7:0]                  csum;
		logic [15:0]                 silence_length;
	} job_t;

	typedef logic [3:0][15:0] freq_table_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_PILOT,
		PH_SYNC,
		PH_BYTE,
		PH_CSUM,
		PH_END,
		PH_SILENCE
	} phase_t;

endpackage

FILE: rtl/core/tape_dibit_frame_encoder_top.sv
// Top level of the cassette record tone encoder.
//
//   channel   direction  handshake               payload
//   request   in         push / full             request_t
//   result    out        pop / empty             result_t
//   config    in         psel/penable/pwrite     paddr, pwdata -> prdata (pready tied high)
//
// The tone sequencer emits one result per cycle while the result queue has room: a plain
// data byte gives 4 results, a record-opening byte 6, a closing byte 9 and a header record 31; a silence gives 1.
// A two-entry item queue lets the front accept while the sequencer works, and a
// two-entry result queue keeps the sequencer running while the consumer stalls.
// Reset clears the queues, the sequencer and the checksum, and loads the default
// symbol frequencies; there is no clearing pass.
module tape_dibit_frame_encoder_top import tdfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  request_t          request,
	output logic              empty,
	input  logic              pop,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	freq_table_t freq;
	job_t        job_in;
	job_t        job_out;
	logic        job_push;
	logic        job_full;
	logic        job_pop;
	logic        job_valid;

	tdfe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.freq    (freq)
	);

	tdfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.request  (request),
		.full     (full),
		.job_full (job_full),
		.job_push (job_push),
		.job      (job_in)
	);

	tdfe_job_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.job_in  (job_in),
		.full    (job_full),
		.pop     (job_pop),
		.job_out (job_out),
		.valid   (job_valid)
	);

	tdfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.freq      (freq),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

FILE: rtl/core/tdfe_cfg.sv
// APB register file holding the four symbol tone frequencies.
module tdfe_cfg import tdfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output freq_table_t       freq
);

	freq_table_t freq_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign freq   = freq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q[0] <= FREQ0_RESET;
			freq_q[1] <= FREQ1_RESET;
			freq_q[2] <= FREQ2_RESET;
			freq_q[3] <= FREQ3_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_FREQ0: freq_q[0] <= pwdata[15:0];
				REG_FREQ1: freq_q[1] <= pwdata[15:0];
				REG_FREQ2: freq_q[2] <= pwdata[15:0];
				REG_FREQ3: freq_q[3] <= pwdata[15:0];
				default:   freq_q    <= freq_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_FREQ0: prdata = {16'b0, freq_q[0]};
			REG_FREQ1: prdata = {16'b0, freq_q[1]};
			REG_FREQ2: prdata = {16'b0, freq_q[2]};
			REG_FREQ3: prdata = {16'b0, freq_q[3]};
			default:   prdata = 32'b0;
		endcase
	end

endmodule

FILE: rtl/core/tdfe_front.sv
// Front end: accepts items, builds header records and keeps the running checksum.
module tdfe_front import tdfe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  request_t request,
	output logic     full,
	input  logic     job_full,
	output logic     job_push,
	output job_t     job
);

	logic [7:0]                csum_q;
	logic                      accept;
	logic                      job_valid;
	logic [7:0]                data_csum;
	logic [7:0]                opcode;
	logic [7:0]                word_lo;
	logic [7:0]                word_hi;
	logic [HDR_BYTES-1:0][7:0] hdr;
	logic [7:0]                hdr_csum;

	assign full     = job_full;
	assign accept   = push && !job_full;
	assign job_push = accept && job_valid;

	// A first byte restarts the checksum even inside an open record.
	assign data_csum = (request.first_flag ? 8'h00 : csum_q) ^ request.data_byte;

	always_comb begin
		unique case (request.action)
			ACT_JUMP: begin
				opcode  = OPC_JMP;
				word_lo = request.jump_word[7:0];
				word_hi = request.jump_word[15:8];
			end
			ACT_CALL: begin
				opcode  = OPC_JSR;
				word_lo = request.jump_word[7:0];
				word_hi = request.jump_word[15:8];
			end
			ACT_RETURN: begin
				opcode  = OPC_RTS;
				word_lo = FILL_WORD[7:0];
				word_hi = FILL_WORD[15:8];
			end
			ACT_CUSTOM: begin
				// The custom word goes out high byte first.
				opcode  = request.jump_word[23:16];
				word_lo = request.jump_word[15:8];
				word_hi = request.jump_word[7:0];
			end
			default: begin
				opcode  = OPC_NOP;
				word_lo = FILL_WORD[7:0];
				word_hi = FILL_WORD[15:8];
			end
		endcase
		hdr[0]   = request.load_address[7:0];
		hdr[1]   = request.load_address[15:8];
		hdr[2]   = MARK_BYTE;
		hdr[3]   = opcode;
		hdr[4]   = word_lo;
		hdr[5]   = word_hi;
		hdr_csum = hdr[0] ^ hdr[1] ^ hdr[2] ^ hdr[3] ^ hdr[4] ^ hdr[5];
	end

	always_comb begin
		job                = '0;
		job.silence_length = request.silence_length;
		job_valid          = 1'b0;
		unique case (request.command)
			CMD_DATA: begin
				job_valid     = 1'b1;
				job.rec_open  = request.first_flag;
				job.rec_close = request.last_flag;
				job.byte_last = 3'd0;
				job.bytes[0]  = request.data_byte;
				job.csum      = data_csum;
			end
			CMD_HEADER: begin
				job_valid     = 1'b1;
				job.rec_open  = 1'b1;
				job.rec_close = 1'b1;
				job.byte_last = HDR_LAST;
				job.bytes     = hdr;
				job.csum      = hdr_csum;
			end
			CMD_SILENCE: begin
				job_valid   = 1'b1;
				job.silence = 1'b1;
			end
			default: begin
				job_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csum_q <= 8'h00;
		end else if (accept) begin
			unique case (request.command)
				CMD_DATA:   csum_q <= request.last_flag ? 8'h00 : data_csum;
				CMD_HEADER: csum_q <= 8'h00;
				default:    csum_q <= csum_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/tdfe_job_queue.sv
// Two-entry queue of classified items between the front end and the sequencer.
module tdfe_job_queue import tdfe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t job_in,
	output logic full,
	input  logic pop,
	output job_t job_out,
	output logic valid
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign job_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: rtl/core/tdfe_back.sv
// Back end: steps through one item's tones and queues one result per cycle while its result queue has room.
module tdfe_back import tdfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        job,
	input  logic        job_valid,
	output logic        job_pop,
	input  freq_table_t freq,
	input  logic        pop,
	output logic        empty,
	output result_t     result
);

	phase_t     phase_q;
	phase_t     phase_n;
	phase_t     cur;
	phase_t     start_phase;
	logic [2:0] idx_q;
	logic [2:0] idx_n;
	logic [1:0] pair_q;
	logic [1:0] pair_n;
	logic [7:0] cur_byte;
	logic [1:0] sym;
	result_t    res;
	logic       emit;

	result_t    oq_q [2];
	logic       oq_wr_q;
	logic       oq_rd_q;
	logic [1:0] oq_cnt_q;
	logic       oq_pop;
	logic       oq_space;

	assign empty    = (oq_cnt_q == 2'd0);
	assign result   = oq_q[oq_rd_q];
	assign oq_pop   = pop && !empty;
	assign oq_space = (oq_cnt_q != 2'd2) || oq_pop;
	assign emit     = job_valid && oq_space;
	assign job_pop  = emit && res.last;

	// A fresh item picks its own entry point into the tone sequence.
	assign start_phase = job.silence ? PH_SILENCE : (job.rec_open ? PH_PILOT : PH_BYTE);
	assign cur         = (phase_q == PH_START) ? start_phase : phase_q;
	assign cur_byte    = (cur == PH_CSUM) ? job.csum : job.bytes[idx_q];

	always_comb begin
		case (pair_q)
			2'd0:    sym = cur_byte[7:6];
			2'd1:    sym = cur_byte[5:4];
			2'd2:    sym = cur_byte[3:2];
			default: sym = cur_byte[1:0];
		endcase
	end

	// Result for the current step
	always_comb begin
		res = '0;
		unique case (cur)
			PH_PILOT: begin
				res.tone_kind    = KIND_PILOT;
				res.frequency_hz = PILOT_FREQ;
				res.cycle_count  = PILOT_CYCLES;
			end
			PH_SYNC: begin
				res.tone_kind    = KIND_SYNC;
				res.frequency_hz = SYNC_FREQ;
				res.cycle_count  = SYNC_CYCLES;
			end
			PH_BYTE: begin
				res.tone_kind    = KIND_DATA;
				res.symbol       = sym;
				res.frequency_hz = freq[sym];
				res.cycle_count  = SYMBOL_CYCLES;
				res.last         = (pair_q == 2'd3) && (idx_q == job.byte_last) &&
					!job.rec_close;
			end
			PH_CSUM: begin
				res.tone_kind    = KIND_DATA;
				res.symbol       = sym;
				res.frequency_hz = freq[sym];
				res.cycle_count  = SYMBOL_CYCLES;
			end
			PH_END: begin
				res.tone_kind    = KIND_END;
				res.frequency_hz = END_FREQ;
				res.cycle_count  = END_CYCLES;
				res.last         = 1'b1;
			end
			PH_SILENCE: begin
				res.tone_kind    = KIND_SILENCE;
				res.cycle_count  = job.silence_length;
				res.last         = 1'b1;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// Next step
	always_comb begin
		phase_n = phase_q;
		idx_n   = idx_q;
		pair_n  = pair_q;
		if (emit) begin
			unique case (cur)
				PH_PILOT: phase_n = PH_SYNC;
				PH_SYNC:  phase_n = PH_BYTE;
				PH_BYTE: begin
					pair_n  = pair_q + 2'd1;
					phase_n = PH_BYTE;
					if (pair_q == 2'd3) begin
						if (idx_q == job.byte_last) begin
							idx_n   = 3'd0;
							phase_n = job.rec_close ? PH_CSUM : PH_START;
						end else begin
							idx_n = idx_q + 3'd1;
						end
					end
				end
				PH_CSUM: begin
					pair_n  = pair_q + 2'd1;
					phase_n = (pair_q == 2'd3) ? PH_END : PH_CSUM;
				end
				PH_END:     phase_n = PH_START;
				PH_SILENCE: phase_n = PH_START;
				default:    phase_n = PH_START;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			idx_q   <= 3'd0;
			pair_q  <= 2'd0;
		end else begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			pair_q  <= pair_n;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			oq_q[oq_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (emit) begin
				oq_wr_q <= ~oq_wr_q;
			end
			if (oq_pop) begin
				oq_rd_q <= ~oq_rd_q;
			end
			oq_cnt_q <= oq_cnt_q + {1'b0, emit} - {1'b0, oq_pop};
		end
	end

endmodule

FILE: rtl/core/tdfe_checker.sv
// Port-level checks of the tone encoder, bound to the top level.
module tdfe_checker import tdfe_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	// A waiting result holds while the consumer stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while stalled");

	// A silence is always alone and carries no tone.
	a_silence: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.tone_kind == KIND_SILENCE |->
			result.last && result.frequency_hz == 16'd0 && result.symbol == 2'd0)
		else $error("malformed silence result");

	// A pilot opens a record, so it never ends an item.
	a_pilot: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.tone_kind == KIND_PILOT |->
			!result.last && result.cycle_count == PILOT_CYCLES &&
			result.frequency_hz == PILOT_FREQ)
		else $error("malformed pilot result");

	// Every data symbol carries SYMBOL_CYCLES as its cycle count.
	a_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.tone_kind == KIND_DATA |-> result.cycle_count == SYMBOL_CYCLES)
		else $error("data symbol with wrong cycle count");

endmodule

bind tape_dibit_frame_encoder_top tdfe_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the cassette record tone encoder top level.
module testbench import tdfe_pkg::*; ;

	localparam logic [1:0] CMD_IGNORED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned PHASE_ITEMS = 62;

	// Predicts the tone stream of the encoder and checks the results against it.
	class tone_tracker;
		logic [15:0] symbol_freq [4];
		logic [7:0]  checksum;
		result_t     pending_tones [$];
		int unsigned failures;

		function new();
			symbol_freq[0] = FREQ0_RESET;
			symbol_freq[1] = FREQ1_RESET;
			symbol_freq[2] = FREQ2_RESET;
			symbol_freq[3] = FREQ3_RESET;
			checksum = '0;
			failures = 0;
		endfunction

		function void set_freq(logic [1:0] idx, logic [15:0] hz);
			symbol_freq[idx] = hz;
		endfunction

		function void add_tone(logic [2:0] kind, logic [1:0] sym, logic [15:0] hz,
			logic [15:0] cycles);
			result_t t;
			t.tone_kind = kind;
			t.symbol = sym;
			t.frequency_hz = hz;
			t.cycle_count = cycles;
			t.last = 1'b0;
			pending_tones.push_back(t);
		endfunction

		function void add_byte(logic [7:0] b);
			logic [1:0] s;
			for (int i = 3; i >= 0; i--) begin
				s = b[2*i +: 2];
				add_tone(KIND_DATA, s, symbol_freq[s], SYMBOL_CYCLES);
			end
		endfunction

		function void add_open();
			add_tone(KIND_PILOT, 2'd0, PILOT_FREQ, PILOT_CYCLES);
			add_tone(KIND_SYNC, 2'd0, SYNC_FREQ, SYNC_CYCLES);
		endfunction

		function void add_close(logic [7:0] sum);
			add_byte(sum);
			add_tone(KIND_END, 2'd0, END_FREQ, END_CYCLES);
		endfunction

		function void note_request(request_t rq);
			int unsigned start;
			logic [7:0] hdr [HDR_BYTES];
			logic [7:0] sum;
			start = pending_tones.size();
			case (rq.command)
				CMD_DATA: begin
					if (rq.first_flag) begin
						add_open();
						checksum = '0;
					end
					add_byte(rq.data_byte);
					checksum ^= rq.data_byte;
					if (rq.last_flag) begin
						add_close(checksum);
						checksum = '0;
					end
				end
				CMD_HEADER: begin
					hdr[0] = rq.load_address[7:0];
					hdr[1] = rq.load_address[15:8];
					hdr[2] = MARK_BYTE;
					case (rq.action)
						ACT_JUMP: begin
							hdr[3] = OPC_JMP;
							hdr[4] = rq.jump_word[7:0];
							hdr[5] = rq.jump_word[15:8];
						end
						ACT_CALL: begin
							hdr[3] = OPC_JSR;
							hdr[4] = rq.jump_word[7:0];
							hdr[5] = rq.jump_word[15:8];
						end
						ACT_RETURN: begin
							hdr[3] = OPC_RTS;
							hdr[4] = FILL_WORD[7:0];
							hdr[5] = FILL_WORD[15:8];
						end
						ACT_CUSTOM: begin
							// The custom word is sent high byte first.
							hdr[3] = rq.jump_word[23:16];
							hdr[4] = rq.jump_word[15:8];
							hdr[5] = rq.jump_word[7:0];
						end
						default: begin
							hdr[3] = OPC_NOP;
							hdr[4] = FILL_WORD[7:0];
							hdr[5] = FILL_WORD[15:8];
						end
					endcase
					sum = '0;
					add_open();
					for (int i = 0; i < HDR_BYTES; i++) begin
						add_byte(hdr[i]);
						sum ^= hdr[i];
					end
					add_close(sum);
					checksum = '0;
				end
				CMD_SILENCE: add_tone(KIND_SILENCE, 2'd0, 16'd0, rq.silence_length);
				default: ;
			endcase
			if (pending_tones.size() > start)
				pending_tones[pending_tones.size() - 1].last = 1'b1;
		endfunction

		function void flag(string field, logic [15:0] want, logic [15:0] got);
			failures++;
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
		endfunction

		function void check_tone(result_t got);
			result_t want;
			if (pending_tones.size() == 0) begin
				flag("unexpected tone, kind", 16'hFFFF, 16'(got.tone_kind));
				return;
			end
			want = pending_tones.pop_front();
			if (got.tone_kind !== want.tone_kind)
				flag("tone_kind", 16'(want.tone_kind), 16'(got.tone_kind));
			if (got.symbol !== want.symbol)
				flag("symbol", 16'(want.symbol), 16'(got.symbol));
			if (got.frequency_hz !== want.frequency_hz)
				flag("frequency_hz", want.frequency_hz, got.frequency_hz);
			if (got.cycle_count !== want.cycle_count)
				flag("cycle_count", want.cycle_count, got.cycle_count);
			if (got.last !== want.last)
				flag("last", 16'(want.last), 16'(got.last));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	request_t          request;
	logic              empty;
	logic              pop;
	result_t           result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	tone_tracker tones = new();
	int unsigned send_idle = 0;
	int unsigned pop_stall = 0;
	int unsigned cycles = 0;

	tape_dibit_frame_encoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.request(request),
		.empty(empty),
		.pop(pop),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tape_dibit_frame_encoder_top test failed");
			$finish;
		end
	end

	// Handshakes are sampled at the edge, before the block updates its outputs.
	always @(posedge clk) begin
		if (push && !full)
			tones.note_request(request);
		if (pop && !empty)
			tones.check_tone(result);
	end

	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			pop <= ($urandom_range(0, 99) >= pop_stall);
			@(posedge clk);
		end
	end

	function automatic request_t random_request();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return request_t'(raw[$bits(request_t)-1:0]);
	endfunction

	task automatic send(request_t rq);
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		request <= rq;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_data(logic [7:0] b, logic first, logic closing);
		request_t rq;
		rq = random_request();
		rq.command = CMD_DATA;
		rq.data_byte = b;
		rq.first_flag = first;
		rq.last_flag = closing;
		send(rq);
	endtask

	task automatic send_header(logic [15:0] addr, logic [2:0] act, logic [23:0] jw);
		request_t rq;
		rq = random_request();
		rq.command = CMD_HEADER;
		rq.load_address = addr;
		rq.action = act;
		rq.jump_word = jw;
		send(rq);
	endtask

	task automatic send_silence(logic [15:0] len);
		request_t rq;
		rq = random_request();
		rq.command = CMD_SILENCE;
		rq.silence_length = len;
		send(rq);
	endtask

	// Holds the sender off until every predicted tone has come out.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (tones.pending_tones.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] hz);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), hz};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tones.set_freq(idx, hz);
	endtask

	task automatic run_random(int unsigned items);
		int unsigned counted;
		int unsigned pick;
		int unsigned len;
		request_t rq;
		counted = 0;
		while (counted < items) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					send_data(8'($urandom), i == 0, i == len - 1);
				counted += len;
			end else if (pick < 70) begin
				send_header(16'($urandom), 3'($urandom), 24'($urandom));
				counted++;
			end else if (pick < 80) begin
				send_silence(16'($urandom));
				counted++;
			end else begin
				// Loose items: stray flags, broken records and ignored commands.
				rq = random_request();
				send(rq);
				if (rq.command != CMD_IGNORED)
					counted++;
			end
			if ($urandom_range(0, 39) == 0)
				drain();
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		request = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_header(16'h0000, ACT_JUMP, 24'hFFFFFF);
		send_header(16'hFFFF, ACT_CALL, 24'h000000);
		send_header(16'h1234, ACT_NOP, 24'h5A5A5A);
		send_header(16'h8001, ACT_RETURN, 24'h123456);
		send_header(16'h0C00, ACT_CUSTOM, 24'hA55A3C);
		for (int a = ACT_CUSTOM + 1; a < 8; a++)
			send_header(16'($urandom), 3'(a), 24'($urandom));
		send_data(8'h00, 1'b1, 1'b0);
		send_data(8'hFF, 1'b0, 1'b0);
		send_data(8'hA5, 1'b0, 1'b1);
		send_data(8'h81, 1'b1, 1'b1);
		// A byte outside any record opens one without a pilot.
		send_data(8'h3C, 1'b0, 1'b0);
		send_data(8'hC3, 1'b0, 1'b1);
		// A first byte inside an open record starts it over.
		send_data(8'h12, 1'b1, 1'b0);
		send_data(8'h34, 1'b1, 1'b0);
		send_data(8'h56, 1'b0, 1'b1);
		// A header abandons the open record and its checksum.
		send_data(8'h77, 1'b1, 1'b0);
		send_header(16'h0800, ACT_JUMP, 24'h000800);
		send_data(8'h99, 1'b0, 1'b1);
		send_silence(16'h0000);
		send_silence(16'hFFFF);
		begin
			request_t rq;
			rq = random_request();
			rq.command = CMD_IGNORED;
			send(rq);
		end
		drain();

		write_reg(REG_FREQ0, 16'h0000);
		write_reg(REG_FREQ1, 16'hFFFF);
		write_reg(REG_FREQ2, 16'($urandom));
		write_reg(REG_FREQ3, 16'($urandom));
		run_random(PHASE_ITEMS);

		write_reg(REG_FREQ0, 16'hFFFF);
		write_reg(REG_FREQ1, 16'hFFFF);
		write_reg(REG_FREQ2, 16'hFFFF);
		write_reg(REG_FREQ3, 16'hFFFF);
		send_idle = 82;
		run_random(PHASE_ITEMS);

		write_reg(REG_FREQ0, 16'h0000);
		write_reg(REG_FREQ1, 16'h0000);
		write_reg(REG_FREQ2, 16'h0000);
		write_reg(REG_FREQ3, 16'h0000);
		send_idle = 0;
		pop_stall = 82;
		run_random(PHASE_ITEMS);

		write_reg(REG_FREQ0, 16'($urandom));
		write_reg(REG_FREQ1, 16'($urandom));
		write_reg(REG_FREQ2, 16'($urandom));
		write_reg(REG_FREQ3, 16'($urandom));
		send_idle = 35;
		pop_stall = 35;
		run_random(PHASE_ITEMS);

		if (tones.failures == 0 && tones.pending_tones.size() == 0)
			$display("tape_dibit_frame_encoder_top test passed");
		else
			$display("tape_dibit_frame_encoder_top test failed");
		$finish;
	end

endmodule
